### sv/dgp_pkg.sv
`timescale 1ns / 1ps
package dgp_pkg;

  localparam int unsigned FracBits = 16;

  localparam logic [30:0] Max31     = 31'h7FFF_FFFF;
  localparam logic [31:0] Ln2Q32    = 32'd2977044472;
  localparam logic [31:0] OneQ      = 32'h0001_0000;

  localparam logic [30:0] StepReset   = 31'd65536;
  localparam logic [30:0] ShrinkReset = 31'd65536;
  localparam logic [31:0] ClampLoRst  = 32'hFFF6_0000;  // -10.0
  localparam logic [31:0] ClampHiRst  = 32'h000A_0000;  // +10.0

  typedef enum logic [1:0] {
    REG_STEP_SCALE   = 2'd0,
    REG_SHRINK_WIDTH = 2'd1,
    REG_CLAMP_LOW    = 2'd2,
    REG_CLAMP_HIGH   = 2'd3
  } reg_idx_e;

endpackage

### sv/diagonal_gaussian_proposal_core.sv
`timescale 1ns / 1ps
// Channel   | Dir | Beat contents
// ----------+-----+------------------------------------------------------------
// s_axis    | in  | tdata: grad_value, second_moment; tuser: prior_only; tlast: last_dim
// m_axis    | out | tdata: mean_out, inv_cov_out, std_dev_out, log_det_out;
//           |     | tuser: saturated; tlast: last_out
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i, one register per cycle
//
// The work runs through the shared 33-step restoring divider (three reciprocals),
// the 24-step square root, the leading-one search and 16 squarings of the log;
// a prior-only beat takes only its first reciprocal and the log.
// A zero or above-2^32 divisor skips its divider pass; zero precision skips the log.
// Multiplies share one 32x32 multiplier; divider and square root each have their own compare.
// Reset clears the log-determinant accumulator and loads default registers.
// A result waiting on m_axis stalls only the final accumulate step; input ready returns
// in the same cycle as the result appears on m_axis.
module diagonal_gaussian_proposal_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // grad_value[31:0], second_moment[62:32]
  input  logic          s_axis_tuser,   // prior_only
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // mean[31:0], inv_cov[62:32], std_dev[93:63],
                                        // log_det[125:94]
  output logic          m_axis_tuser,   // saturated
  output logic          m_axis_tlast,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);
  import dgp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MW, S_SHRK, S_DIV, S_SHRKD, S_MS, S_MVLO, S_MVHI, S_VAR, S_INV,
    S_SQI, S_SQRT, S_MM, S_MEAN, S_LOGCHK, S_NORM, S_LSQM, S_LSQU, S_LNM, S_LNR,
    S_ACC
  } state_e;

  typedef enum logic [1:0] {DS_SHRK, DS_VAR, DS_COV} dsel_e;

  state_e state_q, state_d;
  dsel_e  dsel_q, dsel_d;
  logic [5:0]  cnt_q, cnt_d;
  logic signed [31:0] g_q, g_d;
  logic [30:0] m_q, m_d;
  logic prior_q, prior_d, last_q, last_d, sat_q, sat_d;
  logic [30:0] step_q, step_d, shr_q, shr_d;
  logic signed [31:0] clo_q, clo_d, chi_q, chi_d;
  logic [63:0] prod_q, lo_q, lo_d;
  logic [13:0] wk_q, wk_d;
  logic [32:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [30:0] res_q, res_d, shrk_q, shrk_d, inv_q, inv_d, cov_q, cov_d, std_q, std_d;
  logic [31:0] mean_q, mean_d;
  logic gneg_q, gneg_d;
  logic [47:0] sv_q, sv_d;
  logic [25:0] srem_q, srem_d;
  logic [23:0] root_q, root_d;
  logic [30:0] y_q, y_d;
  logic [4:0]  k_q, k_d;
  logic [15:0] frac_q, frac_d;
  logic lneg_q, lneg_d;
  logic signed [31:0] lg_q, lg_d, acc_q, acc_d;
  logic [127:0] otd_q, otd_d;
  logic ov_q, ov_d, olast_q, olast_d, ouser_q, ouser_d;

  logic [31:0] mul_a, mul_b;
  logic        dreq;
  logic [61:0] dv;
  state_e      dnext;

  // recurrence temporaries
  logic [33:0] r2;
  logic        dge;
  logic [32:0] qnew;
  logic [95:0] vf;
  logic [31:0] isum, mp1;
  logic [30:0] invv;
  logic [26:0] rr;
  logic        sge;
  logic [26:0] sdiff;
  logic signed [31:0] gc;
  logic [31:0] gmag;
  logic [46:0] pm;
  logic [33:0] t;
  logic signed [5:0]  kk;
  logic [21:0] l2, l2m;
  logic [64:0] lsum;
  logic [31:0] rmag;
  logic signed [32:0] asum;
  logic signed [31:0] accs;
  logic asat;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = otd_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ouser_q;

  assign mp1 = {1'b0, m_q} + OneQ;

  always_comb begin
    state_d = state_q;  dsel_d = dsel_q;  cnt_d = cnt_q;
    g_d = g_q;  m_d = m_q;  prior_d = prior_q;  last_d = last_q;  sat_d = sat_q;
    step_d = step_q;  shr_d = shr_q;  clo_d = clo_q;  chi_d = chi_q;
    lo_d = lo_q;  wk_d = wk_q;  rem_d = rem_q;  quo_d = quo_q;  dvs_d = dvs_q;
    res_d = res_q;  shrk_d = shrk_q;  inv_d = inv_q;  cov_d = cov_q;  std_d = std_q;
    mean_d = mean_q;  gneg_d = gneg_q;  sv_d = sv_q;  srem_d = srem_q;  root_d = root_q;
    y_d = y_q;  k_d = k_q;  frac_d = frac_q;  lneg_d = lneg_q;  lg_d = lg_q;
    acc_d = acc_q;  otd_d = otd_q;  ov_d = ov_q;  olast_d = olast_q;  ouser_d = ouser_q;
    mul_a = '0;  mul_b = '0;
    dreq = 1'b0;  dv = '0;
    vf = '0;  isum = '0;  invv = '0;
    r2 = {rem_q, (cnt_q == 6'd32)};
    dge = (r2 >= {1'b0, dvs_q});
    qnew = {quo_q[31:0], dge};
    rr = {srem_q[24:0], sv_q[47:46]};
    sge = (rr >= {1'b0, root_q, 2'b01});
    sdiff = rr - {1'b0, root_q, 2'b01};
    gc = (g_q < clo_q) ? clo_q : ((g_q > chi_q) ? chi_q : g_q);
    gmag = gc[31] ? (~gc + 32'd1) : gc;
    pm = prod_q[63:17];
    t = prod_q[63:30];
    kk = $signed({1'b0, k_q}) - 6'sd16;
    l2 = {kk, frac_q};
    l2m = l2[21] ? (~l2 + 22'd1) : l2;
    lsum = {1'b0, prod_q} + 65'h0_8000_0000;
    rmag = lsum[63:32];
    asum = {acc_q[31], acc_q} + {lg_q[31], lg_q};
    asat = (asum > 33'sd2147483647) || (asum < -33'sd2147483648);
    accs = (asum > 33'sd2147483647) ? 32'sh7FFF_FFFF :
           ((asum < -33'sd2147483648) ? 32'sh8000_0000 : asum[31:0]);

    if (m_axis_tready && ov_q) ov_d = 1'b0;

    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_STEP_SCALE:   step_d = cfg_wdata_i[30:0];
        REG_SHRINK_WIDTH: shr_d  = cfg_wdata_i[30:0];
        REG_CLAMP_LOW:    clo_d  = cfg_wdata_i;
        REG_CLAMP_HIGH:   chi_d  = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          g_d = s_axis_tdata[31:0];
          m_d = s_axis_tdata[62:32];
          prior_d = s_axis_tuser;
          last_d = s_axis_tlast;
          sat_d = 1'b0;
          state_d = S_MW;
        end
      end
      S_MW: begin
        mul_a = {1'b0, shr_q};  mul_b = {1'b0, shr_q};
        state_d = S_SHRK;
      end
      S_SHRK: begin
        dreq = 1'b1;  dv = {14'b0, prod_q[63:16]};  dsel_d = DS_SHRK;
      end
      S_DIV: begin
        rem_d = dge ? r2[32:0] - dvs_q : r2[32:0];
        quo_d = qnew;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          if (qnew > {2'b0, Max31}) begin
            res_d = Max31;  sat_d = 1'b1;
          end else begin
            res_d = qnew[30:0];
          end
          state_d = dnext;
        end
      end
      S_SHRKD: begin
        shrk_d = res_q;
        if (prior_q) begin
          inv_d = res_q;  std_d = shr_q;  mean_d = '0;
          state_d = S_LOGCHK;
        end else begin
          state_d = S_MS;
        end
      end
      S_MS: begin
        mul_a = {1'b0, step_q};  mul_b = {1'b0, step_q};
        state_d = S_MVLO;
      end
      S_MVLO: begin
        mul_a = prod_q[47:16];  mul_b = mp1;
        wk_d = prod_q[61:48];
        state_d = S_MVHI;
      end
      S_MVHI: begin
        lo_d = prod_q;
        mul_a = {18'b0, wk_q};  mul_b = mp1;
        state_d = S_VAR;
      end
      S_VAR: begin
        vf = {prod_q, 32'b0} + {32'b0, lo_q};
        dreq = 1'b1;  dv = vf[77:16];  dsel_d = DS_VAR;
      end
      S_INV: begin
        isum = {1'b0, res_q} + {1'b0, shrk_q};
        if (isum > {1'b0, Max31}) begin
          invv = Max31;  sat_d = 1'b1;
        end else begin
          invv = isum[30:0];
        end
        inv_d = invv;
        dreq = 1'b1;  dv = {31'b0, invv};  dsel_d = DS_COV;
      end
      S_SQI: begin
        cov_d = res_q;
        sv_d = {1'b0, res_q, 16'b0};
        srem_d = '0;  root_d = '0;  cnt_d = 6'd23;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        srem_d = sge ? sdiff[25:0] : rr[25:0];
        root_d = {root_q[22:0], sge};
        sv_d = {sv_q[45:0], 2'b00};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          std_d = {7'b0, root_q[22:0], sge};
          state_d = S_MM;
        end
      end
      S_MM: begin
        mul_a = gmag;  mul_b = {1'b0, cov_q};
        gneg_d = gc[31];
        state_d = S_MEAN;
      end
      S_MEAN: begin
        if (gneg_q) begin
          if (pm > 47'h0_8000_0000) begin
            mean_d = 32'h8000_0000;  sat_d = 1'b1;
          end else begin
            mean_d = 32'd0 - pm[31:0];
          end
        end else begin
          if (pm > {16'b0, Max31}) begin
            mean_d = {1'b0, Max31};  sat_d = 1'b1;
          end else begin
            mean_d = pm[31:0];
          end
        end
        state_d = S_LOGCHK;
      end
      S_LOGCHK: begin
        if (inv_q == '0) begin
          lg_d = 32'sh8000_0000;  sat_d = 1'b1;
          state_d = S_ACC;
        end else begin
          y_d = inv_q;  k_d = 5'd30;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        // leading-one search, one position per cycle
        if (y_q[30]) begin
          cnt_d = 6'd15;  frac_d = '0;
          state_d = S_LSQM;
        end else begin
          y_d = {y_q[29:0], 1'b0};
          k_d = k_q - 5'd1;
        end
      end
      S_LSQM: begin
        mul_a = {1'b0, y_q};  mul_b = {1'b0, y_q};
        state_d = S_LSQU;
      end
      S_LSQU: begin
        if (|t[33:31]) begin
          y_d = t[31:1];  frac_d = {frac_q[14:0], 1'b1};
        end else begin
          y_d = t[30:0];  frac_d = {frac_q[14:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        state_d = (cnt_q == 6'd0) ? S_LNM : S_LSQM;
      end
      S_LNM: begin
        mul_a = {10'b0, l2m};  mul_b = Ln2Q32;
        lneg_d = l2[21];
        state_d = S_LNR;
      end
      S_LNR: begin
        lg_d = lneg_q ? (32'sd0 - $signed(rmag)) : $signed(rmag);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (!ov_q || m_axis_tready) begin
          otd_d = {2'b00, (last_q ? accs : 32'sd0), std_q, inv_q, mean_q};
          ouser_d = sat_q | asat;
          olast_d = last_q;
          ov_d = 1'b1;
          acc_d = last_q ? 32'sd0 : accs;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // common reciprocal entry: zero and out-of-range divisors bypass the divider
    if (dreq) begin
      if (dv == '0) begin
        res_d = Max31;  sat_d = 1'b1;  state_d = dnext;
      end else if ((|dv[61:33]) || (dv[32] && (|dv[31:0]))) begin
        res_d = '0;  state_d = dnext;
      end else begin
        dvs_d = dv[32:0];  rem_d = '0;  quo_d = '0;  cnt_d = 6'd32;
        state_d = S_DIV;
      end
    end
  end

  always_comb begin
    case (dsel_d)
      DS_SHRK: dnext = S_SHRKD;
      DS_VAR:  dnext = S_INV;
      DS_COV:  dnext = S_SQI;
      default: dnext = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      acc_q   <= '0;
      step_q  <= StepReset;
      shr_q   <= ShrinkReset;
      clo_q   <= ClampLoRst;
      chi_q   <= ClampHiRst;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      acc_q   <= acc_d;
      step_q  <= step_d;
      shr_q   <= shr_d;
      clo_q   <= clo_d;
      chi_q   <= chi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    dsel_q <= dsel_d;  cnt_q <= cnt_d;
    g_q <= g_d;  m_q <= m_d;  prior_q <= prior_d;  last_q <= last_d;  sat_q <= sat_d;
    lo_q <= lo_d;  wk_q <= wk_d;  rem_q <= rem_d;  quo_q <= quo_d;  dvs_q <= dvs_d;
    res_q <= res_d;  shrk_q <= shrk_d;  inv_q <= inv_d;  cov_q <= cov_d;  std_q <= std_d;
    mean_q <= mean_d;  gneg_q <= gneg_d;  sv_q <= sv_d;  srem_q <= srem_d;
    root_q <= root_d;  y_q <= y_d;  k_q <= k_d;  frac_q <= frac_d;  lneg_q <= lneg_d;
    lg_q <= lg_d;  otd_q <= otd_d;  olast_q <= olast_d;  ouser_q <= ouser_d;
  end

endmodule

### sv/dgp_checker.sv
`timescale 1ns / 1ps
module dgp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  // the unit stays busy after taking a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

  // log-determinant only reported on the final dimension
  a_logdet_last_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[125:94] == 32'd0)
    else $error("log_det nonzero on non-last beat");

  // zero precision means the log was forced and flagged
  a_zero_inv_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[62:32] == 31'd0 |-> m_axis_tuser)
    else $error("zero inverse covariance without saturated flag");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

endmodule

bind diagonal_gaussian_proposal_core dgp_checker u_dgp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import dgp_pkg::*;

  typedef struct packed {
    logic [31:0] mean;
    logic [30:0] inv_cov;
    logic [30:0] std_dev;
    logic [31:0] log_det;
    logic        last;
    logic        sat;
  } prop_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [63:0]   s_axis_tdata = '0;   // grad_value[31:0], second_moment[62:32]
  logic          s_axis_tuser = 1'b0; // prior_only
  logic          s_axis_tlast = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [127:0]  m_axis_tdata;        // mean, inv_cov, std_dev, log_det
  logic          m_axis_tuser;        // saturated
  logic          m_axis_tlast;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = '0;
  logic [31:0]   cfg_wdata_i = '0;

  diagonal_gaussian_proposal_core uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [30:0]        step_q = StepReset, shrink_q = ShrinkReset;
  logic signed [31:0] clo_q = ClampLoRst, chi_q = ClampHiRst;
  longint             logdet_acc = 0;

  prop_t   proposals_pending[$];
  int      mismatches = 0;
  int      results_seen = 0;
  bit      draining = 1'b0;

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> FracBits;
    return (p > (128'd1 << 50)) ? (64'd1 << 50) : p[63:0];
  endfunction

  function automatic logic [63:0] recip(logic [63:0] x, inout bit sat);
    logic [63:0] q;
    if (x == 0) begin
      sat = 1; return 64'(Max31);
    end
    q = (64'd1 << (2 * FracBits)) / x;
    if (q > 64'(Max31)) begin
      sat = 1; return 64'(Max31);
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint nat_log(logic [63:0] x);
    int k;
    logic [63:0] y, frac, mag;
    longint l2;
    k = 31; frac = 0;
    while (k > 0 && x[k] == 1'b0) k--;
    y = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
    for (int i = 1; i <= FracBits; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y >>= 1; frac[FracBits - i] = 1'b1;
      end
    end
    l2 = longint'(k - int'(FracBits)) * (longint'(1) << FracBits) + longint'(frac);
    mag = (l2 < 0) ? -l2 : l2;
    mag = (mag * 64'(Ln2Q32) + (64'd1 << 31)) >> 32;
    return (l2 < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic prop_t predict_proposal(logic signed [31:0] grad, logic [30:0] moment,
                                             bit prior, bit last);
    prop_t r;
    bit sat;
    logic [63:0] shrk, invcov, stdv, cov, s2, vr, mag;
    longint g, mean, lg;
    sat = 0; mean = 0;
    shrk = recip(mul_shift(shrink_q, shrink_q), sat);
    if (prior) begin
      invcov = shrk; stdv = shrink_q;
    end else begin
      s2 = mul_shift(step_q, step_q);
      vr = mul_shift(s2, 64'(moment) + (64'd1 << FracBits));
      invcov = recip(vr, sat) + shrk;
      if (invcov > 64'(Max31)) begin
        invcov = 64'(Max31); sat = 1;
      end
      cov = recip(invcov, sat);
      stdv = int_sqrt(cov << FracBits);
      g = grad;
      if (g < clo_q) g = clo_q;
      else if (g > chi_q) g = chi_q;
      mag = (g < 0) ? -g : g;
      mag = (mag * cov) >> (FracBits + 1);
      if (g < 0) begin
        if (mag > (64'd1 << 31)) begin
          mag = 64'd1 << 31; sat = 1;
        end
        mean = -longint'(mag);
      end else begin
        if (mag > 64'(Max31)) begin
          mag = 64'(Max31); sat = 1;
        end
        mean = mag;
      end
    end
    if (invcov == 0) begin
      lg = -longint'(64'h8000_0000); sat = 1;
    end else lg = nat_log(invcov);
    logdet_acc += lg;
    if (logdet_acc > 64'sh7FFF_FFFF) begin
      logdet_acc = 64'sh7FFF_FFFF; sat = 1;
    end
    if (logdet_acc < -64'sh8000_0000) begin
      logdet_acc = -64'sh8000_0000; sat = 1;
    end
    r.mean = mean[31:0];
    r.inv_cov = invcov[30:0];
    r.std_dev = stdv[30:0];
    r.log_det = last ? logdet_acc[31:0] : 32'd0;
    r.last = last;
    r.sat = sat;
    if (last) logdet_acc = 0;
    return r;
  endfunction

  // result side: random stalls, check each beat against the oldest prediction
  always @(posedge clk_i) begin
    prop_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.mean = m_axis_tdata[31:0];
      got.inv_cov = m_axis_tdata[62:32];
      got.std_dev = m_axis_tdata[93:63];
      got.log_det = m_axis_tdata[125:94];
      got.last = m_axis_tlast;
      got.sat = m_axis_tuser;
      results_seen++;
      if (proposals_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = proposals_pending.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: mean %h/%h inv %h/%h std %h/%h ld %h/%h last %b/%b sat %b/%b",
                     want.mean, got.mean, want.inv_cov, got.inv_cov, want.std_dev,
                     got.std_dev, want.log_det, got.log_det, want.last, got.last,
                     want.sat, got.sat);
        end
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= 1'b0;
      stall = draining ? 0 : $urandom_range(0, 6);
      repeat (stall) @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  bit no_gaps = 1'b0;

  task automatic send_dim(logic signed [31:0] grad, logic [30:0] moment, bit prior, bit last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    // valid drops between beats; the core is still busy when it returns
    repeat (gap + 1) @(negedge clk_i);
    s_axis_tdata <= {1'b0, moment, grad};
    s_axis_tuser <= prior;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    proposals_pending.push_back(predict_proposal(grad, moment, prior, last));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (proposals_pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_STEP_SCALE:   step_q = val[30:0];
      REG_SHRINK_WIDTH: shrink_q = val[30:0];
      REG_CLAMP_LOW:    clo_q = val;
      default:          chi_q = val;
    endcase
  endtask

  function automatic logic [31:0] rand_q(int mode);
    case (mode)
      0: return $urandom_range(1, 32'h0004_0000);
      1: return $urandom_range(32'h0000_0100, 32'h0100_0000);
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic test_defaults();
    send_dim(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 0);
    send_dim(32'sh8000_0000, 31'd0, 0, 0);
    send_dim(32'sd0, 31'd65536, 0, 0);
    send_dim(32'sh0003_0000, 31'd12345, 1, 1);
    send_dim(-32'sh0001_8000, 31'd1, 0, 1);
    wait_idle();
  endtask

  task automatic test_extreme_regs();
    // tiny step: huge precision, inv_cov clipped
    write_reg(REG_STEP_SCALE, 32'd1);
    send_dim(32'sh0100_0000, 31'd0, 0, 0);
    send_dim(-32'sh0100_0000, 31'h7FFF_FFFF, 0, 1);
    wait_idle();
    // huge widths: shrink term goes to zero, precision zero in prior mode
    write_reg(REG_STEP_SCALE, 32'h7FFF_FFFF);
    write_reg(REG_SHRINK_WIDTH, 32'h7FFF_FFFF);
    write_reg(REG_CLAMP_LOW, 32'h8000_0000);
    write_reg(REG_CLAMP_HIGH, 32'h7FFF_FFFF);
    send_dim(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 0);
    send_dim(32'sh8000_0000, 31'd0, 1, 0);
    send_dim(32'sh8000_0000, 31'd0, 1, 0);
    send_dim(32'sh1234_5678, 31'd777, 0, 1);
    wait_idle();
    // tiny shrink width: reciprocal saturates; clamps stay wide
    write_reg(REG_SHRINK_WIDTH, 32'd1);
    write_reg(REG_STEP_SCALE, 32'd300);
    send_dim(32'sh7FFF_FFFF, 31'd0, 0, 0);
    send_dim(32'sh8000_0000, 31'd0, 0, 0);
    send_dim(32'sd5, 31'd5, 1, 1);
    wait_idle();
    // crossed clamps
    write_reg(REG_SHRINK_WIDTH, 32'd65536);
    write_reg(REG_STEP_SCALE, 32'd65536);
    write_reg(REG_CLAMP_LOW, 32'sh0005_0000);
    write_reg(REG_CLAMP_HIGH, -32'sh0005_0000);
    send_dim(32'sh0000_0000, 31'd100, 0, 0);
    send_dim(32'sh0009_0000, 31'd100, 0, 0);
    send_dim(-32'sh0009_0000, 31'd100, 0, 1);
    wait_idle();
  endtask

  // accumulator driven to its negative limit, then fed large positive terms
  task automatic test_accum_saturation();
    write_reg(REG_CLAMP_LOW, ClampLoRst);
    write_reg(REG_CLAMP_HIGH, ClampHiRst);
    write_reg(REG_SHRINK_WIDTH, 32'h7FFF_FFFF);
    write_reg(REG_STEP_SCALE, 32'h7FFF_FFFF);
    for (int i = 0; i < 3; i++) send_dim(32'sd1, 31'd0, 1, i == 2);
    // no write mid-flight, though the core does not enforce it; wait first
    wait_idle();
    write_reg(REG_SHRINK_WIDTH, 32'd1);
    for (int i = 0; i < 3; i++) send_dim(32'sd1, 31'd0, 1, i == 2);
    wait_idle();
  endtask

  task automatic test_random();
    int mode;
    for (int phase = 0; phase < 8; phase++) begin
      mode = $urandom_range(0, 2);
      write_reg(REG_STEP_SCALE, rand_q(mode) | 32'd1);
      write_reg(REG_SHRINK_WIDTH, rand_q($urandom_range(0, 2)) | 32'd1);
      write_reg(REG_CLAMP_LOW, $urandom_range(0, 3) == 0 ? $urandom : -rand_q(1));
      write_reg(REG_CLAMP_HIGH, $urandom_range(0, 3) == 0 ? $urandom : rand_q(1));
      no_gaps = (phase == 3);
      for (int i = 0; i < 225; i++)
        send_dim($urandom, $urandom_range(0, 3) == 0 ? 31'($urandom) :
                 31'($urandom_range(0, 32'h0010_0000)),
                 $urandom_range(0, 4) == 0, $urandom_range(0, 7) == 0);
      send_dim($urandom, 31'd0, 0, 1);
      if (phase == 5) wait_idle();
      // sender held off until drained
      if (phase == 5) for (int i = 0; i < 3; i++) send_dim($urandom, 31'd9, 0, i == 2);
      wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_extreme_regs();
    test_accum_saturation();
    test_random();
    draining = 1'b1;
    wait_idle();
    repeat (400) @(negedge clk_i);
    if (mismatches == 0 && proposals_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

### sim.f
sv/dgp_pkg.sv
sv/diagonal_gaussian_proposal_core.sv
sv/dgp_checker.sv
test/tb.sv
